// ----- src/deadline_timer_table_top_assert.svh -----
// Assertion macros for the deadline timer table.
// Included by deadline_timer_table_top; no other dependencies.
`ifndef DEADLINE_TIMER_TABLE_TOP_ASSERT_SVH
`define DEADLINE_TIMER_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define DTT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define DTT_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);
`else
`define DTT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define DTT_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`endif

`endif

// ----- src/dtt_pkg.sv -----
// Package for the deadline timer table: item structs, entry type, codes, state enum.
// No dependencies.
package dtt_pkg;

    localparam int TIME_W              = 48;
    localparam int ID_W                = 8;
    localparam int DELAY_W             = 32;
    localparam int DEFAULT_MAX_ENTRIES = 32;

    localparam logic FUNC_SCHED  = 1'b0;
    localparam logic FUNC_EXPIRE = 1'b1;

    localparam logic KIND_CLOSE = 1'b0;
    localparam logic KIND_FIRE  = 1'b1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    typedef struct packed {
        logic                func;
        logic [ID_W-1:0]     task_id;
        logic [DELAY_W-1:0]  wait_ms;
        logic [TIME_W-1:0]   now_ms;
    } t_cmd;

    typedef struct packed {
        logic                kind;
        logic [1:0]          status;
        logic [ID_W-1:0]     fired_id;
        logic                next_valid;
        logic [TIME_W-1:0]   next_wait_ms;
        logic                last;
    } t_res;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [TIME_W-1:0]   deadline;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_FINISH,
        ST_CLOSE
    } t_state;

endpackage

// ----- src/dtt_mem.sv -----
// Entry memory of the deadline timer table: one write port, one registered read port.
// Depends on dtt_pkg (t_entry).
module dtt_mem
    import dtt_pkg::*;
#(
    parameter int DEPTH  = DEFAULT_MAX_ENTRIES,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_entry            i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_entry            o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/deadline_timer_table_top.sv -----
// Deadline timer table: keeps up to MAX_ENTRIES pending timeouts (task id plus absolute
// deadline) in table order in one entry memory, read one entry per cycle except while a due
// entry waits on result stall. A schedule item appends an entry; an expire item fires due
// entries in order and compacts the rest in place. Each item ends with a closing result
// that carries the delay to the earliest deadline. One item is handled at a time: commands
// are stalled from acceptance until the item's closing result is issued, and every entry
// is scanned through the single read port of the entry memory.
module deadline_timer_table_top
    import dtt_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    output logic o_cmd_stall,
    input  t_cmd i_cmd,
    output logic o_res_valid,
    input  logic i_res_stall,
    output t_res o_res
);

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_lim, n_lim;
    logic [CNT_W-1:0]  r_rd_idx, n_rd_idx;
    logic              r_rd_vld, n_rd_vld;
    logic [CNT_W-1:0]  r_kept, n_kept;
    logic              r_any, n_any;
    logic [TIME_W-1:0] r_best, n_best;
    logic [1:0]        r_status, n_status;
    logic [TIME_W-1:0] r_nd, n_nd;
    t_res              r_out, n_out;
    logic              r_out_valid;

    logic              out_free;
    logic              load_out;
    logic              advance;
    logic              due;
    logic [TIME_W:0]   sched_sum;
    logic [TIME_W-1:0] sched_dl;

    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    t_entry            mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    t_entry            mem_rd_data;

    dtt_mem #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign out_free  = !r_out_valid || !i_res_stall;
    assign due       = (r_cmd.func == FUNC_EXPIRE) && (mem_rd_data.deadline <= r_cmd.now_ms);
    assign advance   = !r_rd_vld || !due || out_free;
    assign sched_sum = {1'b0, r_cmd.now_ms} + (TIME_W + 1)'(r_cmd.wait_ms);
    assign sched_dl  = sched_sum[TIME_W] ? {TIME_W{1'b1}} : sched_sum[TIME_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: n_state = ST_SCAN;
            ST_SCAN: begin
                if (advance && (r_rd_idx == r_lim)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: n_state = ST_CLOSE;
            ST_CLOSE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_lim       = r_lim;
        n_rd_idx    = r_rd_idx;
        n_rd_vld    = r_rd_vld;
        n_kept      = r_kept;
        n_any       = r_any;
        n_best      = r_best;
        n_status    = r_status;
        n_nd        = r_nd;
        n_out       = r_out;
        load_out    = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_count[ADDR_W-1:0];
        mem_wr_data = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_rd_idx[ADDR_W-1:0];
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                end
            end
            ST_SETUP: begin
                n_rd_idx = '0;
                n_rd_vld = 1'b0;
                n_kept   = '0;
                n_any    = 1'b0;
                n_best   = '0;
                n_lim    = r_count;
                n_status = STAT_OK;
                if (r_cmd.func == FUNC_SCHED) begin
                    if ((r_cmd.task_id == '0) || (r_cmd.wait_ms == '0)) begin
                        n_status = STAT_INVALID;
                    end else if (r_count >= CNT_MAX) begin
                        n_status = STAT_FULL;
                    end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = r_count[ADDR_W-1:0];
                        mem_wr_data = '{id: r_cmd.task_id, deadline: sched_dl};
                        n_any       = 1'b1;
                        n_best      = sched_dl;
                        n_count     = r_count + CNT_W'(1);
                    end
                end
            end
            ST_SCAN: begin
                if (advance) begin
                    if (r_rd_vld) begin
                        if (due) begin
                            load_out = 1'b1;
                            n_out    = '{kind: KIND_FIRE, status: STAT_OK,
                                         fired_id: mem_rd_data.id, next_valid: 1'b0,
                                         next_wait_ms: '0, last: 1'b0};
                        end else begin
                            if (r_cmd.func == FUNC_EXPIRE) begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = r_kept[ADDR_W-1:0];
                                mem_wr_data = mem_rd_data;
                                n_kept      = r_kept + CNT_W'(1);
                            end
                            if (!r_any || (mem_rd_data.deadline < r_best)) begin
                                n_any  = 1'b1;
                                n_best = mem_rd_data.deadline;
                            end
                        end
                    end
                    if (r_rd_idx != r_lim) begin
                        mem_rd_en = 1'b1;
                        n_rd_idx  = r_rd_idx + CNT_W'(1);
                        n_rd_vld  = 1'b1;
                    end else begin
                        n_rd_vld  = 1'b0;
                    end
                end
            end
            ST_FINISH: begin
                if (r_cmd.func == FUNC_EXPIRE) begin
                    n_count = r_kept;
                end
                if (!r_any) begin
                    n_nd = '0;
                end else if (r_best > r_cmd.now_ms) begin
                    n_nd = r_best - r_cmd.now_ms;
                end else begin
                    n_nd = TIME_W'(1);
                end
            end
            ST_CLOSE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_out    = '{kind: KIND_CLOSE, status: r_status, fired_id: '0,
                                 next_valid: r_any, next_wait_ms: r_nd, last: 1'b1};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_lim    <= n_lim;
        r_rd_idx <= n_rd_idx;
        r_kept   <= n_kept;
        r_any    <= n_any;
        r_best   <= n_best;
        r_status <= n_status;
        r_nd     <= n_nd;
        r_out    <= n_out;
    end

    assign o_cmd_stall = (r_state != ST_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

`include "deadline_timer_table_top_assert.svh"

    `DTT_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_MAX, "entry count over limit")
    `DTT_ASSERT_IMP(a_kept_behind, i_clk, i_rst_n, r_state == ST_SCAN, r_kept <= r_rd_idx, "compaction passed the read pointer")
    `DTT_ASSERT_IMP(a_no_rw_clash, i_clk, i_rst_n, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr, "read and write hit one entry")
    `DTT_ASSERT_IMP(a_fire_only_expire, i_clk, i_rst_n, load_out && (n_out.kind == KIND_FIRE), r_cmd.func == FUNC_EXPIRE, "fired item outside expire")

endmodule

// ----- sim/deadline_timer_checker.sv -----
// Checker for the deadline timer table: watches the command and result channels,
// predicts the results of each accepted item and compares them in order.
// Depends on dtt_pkg.
module deadline_timer_checker
    import dtt_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  logic i_cmd_stall,
    input  t_cmd i_cmd,
    input  logic i_res_valid,
    input  logic i_res_stall,
    input  t_res i_res,
    output int   o_fail_count,
    output int   o_pending
);

    logic [TIME_W-1:0] deadline_tbl [MAX_ENTRIES];
    logic [ID_W-1:0]   id_tbl [MAX_ENTRIES];
    int                entry_cnt;
    t_res              expected_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        entry_cnt    = 0;
    end

    function automatic void push_closing(input logic [1:0] stat,
                                         input logic [TIME_W-1:0] now);
        t_res              r;
        logic [TIME_W-1:0] earliest;
        r        = '0;
        earliest = '1;
        for (int i = 0; i < entry_cnt; i++) begin
            if (deadline_tbl[i] < earliest) begin
                earliest = deadline_tbl[i];
            end
        end
        r.kind   = KIND_CLOSE;
        r.status = stat;
        r.last   = 1'b1;
        if (entry_cnt > 0) begin
            r.next_valid   = 1'b1;
            r.next_wait_ms = (earliest > now) ? earliest - now : TIME_W'(1);
        end
        expected_results.push_back(r);
    endfunction

    function automatic void predict_cmd(input t_cmd c);
        logic [TIME_W:0] sum;
        t_res            r;
        int              kept;
        if (c.func == FUNC_SCHED) begin
            if (c.task_id == '0 || c.wait_ms == '0) begin
                push_closing(STAT_INVALID, c.now_ms);
            end else if (entry_cnt >= MAX_ENTRIES) begin
                push_closing(STAT_FULL, c.now_ms);
            end else begin
                sum = {1'b0, c.now_ms} + (TIME_W + 1)'(c.wait_ms);
                deadline_tbl[entry_cnt] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                id_tbl[entry_cnt]       = c.task_id;
                entry_cnt++;
                push_closing(STAT_OK, c.now_ms);
            end
        end else begin
            kept = 0;
            for (int i = 0; i < entry_cnt; i++) begin
                if (deadline_tbl[i] <= c.now_ms) begin
                    r          = '0;
                    r.kind     = KIND_FIRE;
                    r.fired_id = id_tbl[i];
                    expected_results.push_back(r);
                end else begin
                    deadline_tbl[kept] = deadline_tbl[i];
                    id_tbl[kept]       = id_tbl[i];
                    kept++;
                end
            end
            entry_cnt = kept;
            push_closing(STAT_OK, c.now_ms);
        end
    endfunction

    function automatic void check_field(input string name,
                                        input logic [TIME_W-1:0] want,
                                        input logic [TIME_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            o_fail_count = o_fail_count + 1;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_res want;
        if (!i_rst_n) begin
            entry_cnt = 0;
            expected_results.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h", $time, i_res);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, i_res.kind);
                    check_field("status", want.status, i_res.status);
                    check_field("fired_id", want.fired_id, i_res.fired_id);
                    check_field("next_valid", want.next_valid, i_res.next_valid);
                    check_field("next_wait_ms", want.next_wait_ms, i_res.next_wait_ms);
                    check_field("last", want.last, i_res.last);
                end
            end
            if (i_cmd_valid && !i_cmd_stall) begin
                predict_cmd(i_cmd);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- sim/deadline_timer_table_top_test.sv -----
// Testbench top for the deadline timer table: clock, reset, directed and random items,
// random idling on both channels, and the verdict. Depends on dtt_pkg,
// deadline_timer_table_top and deadline_timer_checker.
module deadline_timer_table_top_test;
    import dtt_pkg::*;

    localparam int RANDOM_ITEMS = 430;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 64;
    localparam int IDLE_PCT     = 34;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    t_cmd cmd       = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    t_res res;
    int   fail_count;
    int   pending;
    int   cycle_cnt = 0;
    int   sent_cnt  = 0;
    logic quiet;
    logic [TIME_W-1:0] cur_now;

    // no idling on either side over this stretch of items
    assign quiet = (sent_cnt >= 150) && (sent_cnt < 230);

    deadline_timer_table_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_stall (cmd_stall),
        .i_cmd       (cmd),
        .o_res_valid (res_valid),
        .i_res_stall (res_stall),
        .o_res       (res)
    );

    deadline_timer_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd_stall  (cmd_stall),
        .i_cmd        (cmd),
        .i_res_valid  (res_valid),
        .i_res_stall  (res_stall),
        .i_res        (res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    always @(negedge clk) begin
        res_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_cmd mk_cmd(input logic func, input logic [ID_W-1:0] tid,
                                    input logic [DELAY_W-1:0] dly,
                                    input logic [TIME_W-1:0] now);
        t_cmd c;
        c.func    = func;
        c.task_id = tid;
        c.wait_ms = dly;
        c.now_ms  = now;
        return c;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_cmd(input t_cmd c);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        sent_cnt++;
        @(negedge clk);
    endtask

    initial begin : stimulus
        int episode;
        int rand_base;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_cmd(mk_cmd(FUNC_EXPIRE, '0, '0, '0));                   // empty table
        send_cmd(mk_cmd(FUNC_SCHED, '0, 32'd5, '0));                 // null task
        send_cmd(mk_cmd(FUNC_SCHED, 8'd7, '0, '0));                  // zero delay
        send_cmd(mk_cmd(FUNC_SCHED, '0, '0, 48'd3));
        send_cmd(mk_cmd(FUNC_SCHED, 8'hFF, 32'hFFFF_FFFF, TIME_MAX)); // saturates
        send_cmd(mk_cmd(FUNC_SCHED, 8'd1, 32'd1, '0));
        send_cmd(mk_cmd(FUNC_SCHED, 8'h80, 32'h8000_0000, 48'h7FFF_FFFF_FFFF));
        send_cmd(mk_cmd(FUNC_SCHED, 8'd2, 32'd50, 48'd10));
        send_cmd(mk_cmd(FUNC_EXPIRE, 8'hAA, 32'h5555_5555, '0));      // nothing due
        send_cmd(mk_cmd(FUNC_EXPIRE, '0, '0, 48'd1));
        send_cmd(mk_cmd(FUNC_SCHED, 8'd3, 32'd10, 48'd100));          // earliest already passed
        send_cmd(mk_cmd(FUNC_SCHED, '0, 32'd9, 48'd100));             // rejected, table kept
        send_cmd(mk_cmd(FUNC_EXPIRE, '0, '0, 48'd200));
        send_cmd(mk_cmd(FUNC_EXPIRE, 8'h55, 32'hAAAA_AAAA, TIME_MAX)); // drains all
        send_cmd(mk_cmd(FUNC_EXPIRE, '0, '0, 48'd5));

        rand_base = sent_cnt;
        cur_now   = 48'd1000;
        episode   = 7;
        while (sent_cnt - rand_base < RANDOM_ITEMS) begin
            case (episode)
                0, 1, 2, 3, 4: begin
                    repeat ($urandom_range(1, 8)) begin
                        send_cmd(mk_cmd(FUNC_SCHED,
                            ($urandom_range(0, 11) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                            ($urandom_range(0, 15) == 0) ? 32'd0 :
                            ($urandom_range(0, 7) == 0) ? 32'($urandom) :
                                                          32'($urandom_range(1, 200)),
                            cur_now));
                        cur_now += TIME_W'($urandom_range(0, 20));
                    end
                end
                5, 6: begin
                    cur_now += TIME_W'($urandom_range(0, 300));
                    send_cmd(mk_cmd(FUNC_EXPIRE, 8'($urandom), $urandom, cur_now));
                end
                7: begin
                    // fill the table and push past full
                    repeat (36) begin
                        send_cmd(mk_cmd(FUNC_SCHED, 8'($urandom_range(1, 255)),
                                        $urandom_range(1, 500), cur_now));
                    end
                end
                8: begin
                    if ($urandom_range(0, 1) == 1) begin
                        cur_now = TIME_W'({$urandom, $urandom});
                    end else begin
                        cur_now = TIME_MAX - TIME_W'($urandom_range(0, 1000));
                    end
                    send_cmd(mk_cmd(1'($urandom_range(0, 1)), 8'($urandom), $urandom,
                                    cur_now));
                end
                default: begin
                    send_cmd(mk_cmd(FUNC_EXPIRE, 8'($urandom), $urandom,
                        ($urandom_range(0, 3) == 0) ? TIME_MAX :
                            cur_now + TIME_W'($urandom_range(300, 5000))));
                end
            endcase
            episode = $urandom_range(0, 9);
        end
        cmd_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
